### rtl/dqpi_pkg.sv
package dqpi_pkg;

    localparam int unsigned LIMIT_RADIUS = 11351;
    localparam int unsigned DECAY_Q16    = 64881;
    localparam int unsigned MOD_SCALE    = 96;
    localparam int unsigned VBUS_MIN     = 256;

    localparam int unsigned DIV_STEPS  = 45;
    localparam int unsigned SQRT_STEPS = 32;

    // configuration register indexes
    localparam logic [2:0] REG_BUS_VOLTAGE  = 3'd0;
    localparam logic [2:0] REG_PROP_GAIN_D  = 3'd1;
    localparam logic [2:0] REG_INTEG_GAIN_D = 3'd2;
    localparam logic [2:0] REG_PROP_GAIN_Q  = 3'd3;
    localparam logic [2:0] REG_INTEG_GAIN_Q = 3'd4;

    // lane operations
    localparam logic [3:0] LN_NOP   = 4'd0;
    localparam logic [3:0] LN_LOAD  = 4'd1;
    localparam logic [3:0] LN_MUL   = 4'd2;
    localparam logic [3:0] LN_VOLT  = 4'd3;
    localparam logic [3:0] LN_NUM   = 4'd4;
    localparam logic [3:0] LN_DIV   = 4'd5;
    localparam logic [3:0] LN_MOD   = 4'd6;
    localparam logic [3:0] LN_SQR   = 4'd7;
    localparam logic [3:0] LN_LOAD2 = 4'd8;
    localparam logic [3:0] LN_OUTP  = 4'd9;
    localparam logic [3:0] LN_IMUL  = 4'd10;
    localparam logic [3:0] LN_INTEG = 4'd11;

    // merge operations
    localparam logic [1:0] MG_NOP  = 2'd0;
    localparam logic [1:0] MG_SUM  = 2'd1;
    localparam logic [1:0] MG_STEP = 2'd2;

    typedef struct packed {
        logic [3:0] op;
        logic       lim;
    } lane_ctrl_t;

    typedef struct packed {
        logic [1:0] op;
    } merge_ctrl_t;

endpackage

### rtl/dqpi_lane.sv
module dqpi_lane (
    input  logic                 clk,
    input  logic                 rst_n,
    input  dqpi_pkg::lane_ctrl_t ctrl,
    input  logic [15:0]          reference,
    input  logic [15:0]          measured,
    input  logic [23:0]          prop_gain,
    input  logic [23:0]          integ_gain,
    input  logic [13:0]          bus_voltage,
    input  logic [30:0]          magnitude,
    output logic [61:0]          square,
    output logic [15:0]          modulation
);

    logic signed [16:0] err_reg, err_next;
    logic signed [41:0] prod_reg, prod_next;
    logic               neg_reg, neg_next;
    logic [32:0]        vabs_reg, vabs_next;
    logic [44:0]        div_num_reg, div_num_next;
    logic [30:0]        rem_reg, rem_next;
    logic [30:0]        den_reg, den_next;
    logic [30:0]        mag_reg, mag_next;
    logic [61:0]        sq_reg, sq_next;
    logic [15:0]        mod_reg, mod_next;
    logic signed [48:0] ip_reg, ip_next;
    logic signed [31:0] integ_reg, integ_next;

    logic signed [41:0] prod_adj, prod_tr;
    logic signed [33:0] volt;
    logic [31:0]        rem_sh, rem_diff;
    logic               ge;
    logic signed [48:0] ip_adj, ip_tr;
    logic signed [32:0] integ_sum;

    always_comb
    begin
        prod_adj  = prod_reg + (prod_reg[41] ? 42'sd2047 : 42'sd0);
        prod_tr   = prod_adj >>> 11;
        volt      = 34'(integ_reg) + 34'(prod_tr);
        rem_sh    = {rem_reg, div_num_reg[44]};
        rem_diff  = rem_sh - {1'b0, den_reg};
        ge        = rem_sh >= {1'b0, den_reg};
        if (ctrl.lim)
        begin
            ip_adj = ip_reg + (ip_reg[48] ? 49'sd65535 : 49'sd0);
            ip_tr  = ip_adj >>> 16;
        end
        else
        begin
            ip_adj = ip_reg + (ip_reg[48] ? 49'sd524287 : 49'sd0);
            ip_tr  = ip_adj >>> 19;
        end
        integ_sum = 33'(integ_reg) + 33'(ip_tr);

        err_next     = err_reg;
        prod_next    = prod_reg;
        neg_next     = neg_reg;
        vabs_next    = vabs_reg;
        div_num_next = div_num_reg;
        rem_next     = rem_reg;
        den_next     = den_reg;
        mag_next     = mag_reg;
        sq_next      = sq_reg;
        mod_next     = mod_reg;
        ip_next      = ip_reg;
        integ_next   = integ_reg;

        unique case (ctrl.op)
            dqpi_pkg::LN_LOAD:
                err_next = $signed({reference[15], reference})
                         - $signed({measured[15], measured});
            dqpi_pkg::LN_MUL:
                prod_next = 42'(err_reg) * 42'($signed({1'b0, prop_gain}));
            dqpi_pkg::LN_VOLT:
            begin
                neg_next  = volt[33];
                vabs_next = volt[33] ? 33'(-volt) : volt[32:0];
            end
            dqpi_pkg::LN_NUM:
            begin
                div_num_next = 45'(vabs_reg) * 45'(dqpi_pkg::MOD_SCALE);
                rem_next     = '0;
                den_next     = 31'(bus_voltage);
            end
            dqpi_pkg::LN_DIV:
            begin
                rem_next     = ge ? rem_diff[30:0] : rem_sh[30:0];
                div_num_next = {div_num_reg[43:0], ge};
            end
            dqpi_pkg::LN_MOD:
                mag_next = (div_num_reg > 45'h4000_0000) ? 31'h4000_0000 : div_num_reg[30:0];
            dqpi_pkg::LN_SQR:
                sq_next = 62'(mag_reg) * 62'(mag_reg);
            dqpi_pkg::LN_LOAD2:
            begin
                div_num_next = 45'(mag_reg) * 45'(dqpi_pkg::LIMIT_RADIUS);
                rem_next     = '0;
                den_next     = magnitude;
            end
            dqpi_pkg::LN_OUTP:
            begin
                if (ctrl.lim)
                    mod_next = neg_reg ? 16'(16'd0 - div_num_reg[15:0]) : div_num_reg[15:0];
                else
                    mod_next = neg_reg ? 16'(16'd0 - mag_reg[15:0]) : mag_reg[15:0];
            end
            dqpi_pkg::LN_IMUL:
            begin
                if (ctrl.lim)
                    ip_next = 49'(integ_reg) * 49'(dqpi_pkg::DECAY_Q16);
                else
                    ip_next = 49'(err_reg) * 49'($signed({1'b0, integ_gain}));
            end
            dqpi_pkg::LN_INTEG:
            begin
                if (ctrl.lim)
                    integ_next = ip_tr[31:0];
                else if (integ_sum > 33'sd2147483647)
                    integ_next = 32'sh7FFF_FFFF;
                else if (integ_sum < -33'sd2147483648)
                    integ_next = 32'sh8000_0000;
                else
                    integ_next = integ_sum[31:0];
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        err_reg     <= err_next;
        prod_reg    <= prod_next;
        neg_reg     <= neg_next;
        vabs_reg    <= vabs_next;
        div_num_reg <= div_num_next;
        rem_reg     <= rem_next;
        den_reg     <= den_next;
        mag_reg     <= mag_next;
        sq_reg      <= sq_next;
        mod_reg     <= mod_next;
        ip_reg      <= ip_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            integ_reg <= '0;
        else
            integ_reg <= integ_next;
    end

    assign square     = sq_reg;
    assign modulation = mod_reg;

endmodule

### rtl/dqpi_merge.sv
module dqpi_merge (
    input  logic                  clk,
    input  dqpi_pkg::merge_ctrl_t ctrl,
    input  logic [61:0]           square_d,
    input  logic [61:0]           square_q,
    output logic [30:0]           magnitude,
    output logic                  limited
);

    localparam logic [63:0] RADIUS_SQ = 64'(dqpi_pkg::LIMIT_RADIUS) * 64'(dqpi_pkg::LIMIT_RADIUS);

    logic [63:0] x_reg, x_next;
    logic [63:0] r_reg, r_next;
    logic [63:0] bit_reg, bit_next;
    logic        lim_reg, lim_next;
    logic [63:0] sum, trial;

    always_comb
    begin
        sum      = 64'(square_d) + 64'(square_q);
        trial    = r_reg + bit_reg;
        x_next   = x_reg;
        r_next   = r_reg;
        bit_next = bit_reg;
        lim_next = lim_reg;
        unique case (ctrl.op)
            dqpi_pkg::MG_SUM:
            begin
                x_next   = sum;
                lim_next = sum > RADIUS_SQ;
                r_next   = '0;
                bit_next = 64'd1 << 62;
            end
            dqpi_pkg::MG_STEP:
            begin
                // one result bit of the integer root per step
                if (x_reg >= trial)
                begin
                    x_next = x_reg - trial;
                    r_next = (r_reg >> 1) + bit_reg;
                end
                else
                    r_next = r_reg >> 1;
                bit_next = bit_reg >> 2;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        r_reg   <= r_next;
        bit_reg <= bit_next;
        lim_reg <= lim_next;
    end

    assign magnitude = r_reg[30:0];
    assign limited   = lim_reg;

endmodule

### rtl/dq_current_pi_with_modulation_limit_unit.sv
// dq current PI controller with circular modulation limit.
// Input channel (in_valid/in_ready) takes one request of d/q references and
// measurements; output channel (out_valid/out_ready) returns d/q modulation
// in Q14 and the limited flag, one result per request, in order.
// Two lanes run the d and q axes side by side; a merge stage forms the
// vector length and decides the limit.
// Each lane runs a 45-step restoring divide by bus voltage; when the vector
// is limited, the merge stage then runs the 32-step integer square root
// and each lane a second 45-step divide by the vector length.
// One request is in work at a time; in_ready is high only while idle.
// A finished result waits in the output register; if the receiver stalls,
// the next request is still accepted and worked, and holds at its end until
// the output register frees.
// Reset clears both integrals and returns all gains and the bus voltage to
// their defaults. Configuration writes take effect at once and are meant for
// idle periods only.
module dq_current_pi_with_modulation_limit_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] d_reference,
    input  logic [15:0] q_reference,
    input  logic [15:0] d_measured,
    input  logic [15:0] q_measured,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] d_modulation,
    output logic [15:0] q_modulation,
    output logic        limited
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MUL   = 4'd1;
    localparam logic [3:0] S_VOLT  = 4'd2;
    localparam logic [3:0] S_NUM   = 4'd3;
    localparam logic [3:0] S_DIV1  = 4'd4;
    localparam logic [3:0] S_MOD   = 4'd5;
    localparam logic [3:0] S_SQR   = 4'd6;
    localparam logic [3:0] S_SUM   = 4'd7;
    localparam logic [3:0] S_CHK   = 4'd8;
    localparam logic [3:0] S_SQRT  = 4'd9;
    localparam logic [3:0] S_LOAD2 = 4'd10;
    localparam logic [3:0] S_DIV2  = 4'd11;
    localparam logic [3:0] S_OUTP  = 4'd12;
    localparam logic [3:0] S_IMUL  = 4'd13;
    localparam logic [3:0] S_INTEG = 4'd14;
    localparam logic [3:0] S_FIN   = 4'd15;

    localparam logic [5:0] DIV_LAST  = 6'(dqpi_pkg::DIV_STEPS - 1);
    localparam logic [5:0] SQRT_LAST = 6'(dqpi_pkg::SQRT_STEPS - 1);

    logic [3:0]  state_reg, state_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [13:0] bus_voltage_reg;
    logic [23:0] prop_gain_d_reg, integ_gain_d_reg, prop_gain_q_reg, integ_gain_q_reg;
    logic        out_valid_reg, out_valid_next;
    logic [15:0] d_mod_reg, q_mod_reg;
    logic        lim_out_reg;

    logic [13:0]           vb_eff;
    dqpi_pkg::lane_ctrl_t  lane_ctrl;
    dqpi_pkg::merge_ctrl_t merge_ctrl;
    logic [61:0]           sq_d, sq_q;
    logic [15:0]           mod_d, mod_q;
    logic [30:0]           magnitude;
    logic                  lim;
    logic                  load_out;

    assign vb_eff = (bus_voltage_reg < 14'(dqpi_pkg::VBUS_MIN)) ?
                    14'(dqpi_pkg::VBUS_MIN) : bus_voltage_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bus_voltage_reg  <= 14'd3072;
            prop_gain_d_reg  <= 24'd1088;
            integ_gain_d_reg <= 24'd44254;
            prop_gain_q_reg  <= 24'd1088;
            integ_gain_q_reg <= 24'd44254;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                dqpi_pkg::REG_BUS_VOLTAGE:  bus_voltage_reg  <= cfg_data[13:0];
                dqpi_pkg::REG_PROP_GAIN_D:  prop_gain_d_reg  <= cfg_data;
                dqpi_pkg::REG_INTEG_GAIN_D: integ_gain_d_reg <= cfg_data;
                dqpi_pkg::REG_PROP_GAIN_Q:  prop_gain_q_reg  <= cfg_data;
                dqpi_pkg::REG_INTEG_GAIN_Q: integ_gain_q_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign in_ready = (state_reg == S_IDLE);
    assign load_out = (state_reg == S_FIN) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        lane_ctrl.op   = dqpi_pkg::LN_NOP;
        lane_ctrl.lim  = lim;
        merge_ctrl.op  = dqpi_pkg::MG_NOP;
        out_valid_next = out_valid_reg;
        if (out_ready)
            out_valid_next = 1'b0;
        if (load_out)
            out_valid_next = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    lane_ctrl.op = dqpi_pkg::LN_LOAD;
                    state_next   = S_MUL;
                end
            end
            S_MUL:
            begin
                lane_ctrl.op = dqpi_pkg::LN_MUL;
                state_next   = S_VOLT;
            end
            S_VOLT:
            begin
                lane_ctrl.op = dqpi_pkg::LN_VOLT;
                state_next   = S_NUM;
            end
            S_NUM:
            begin
                lane_ctrl.op = dqpi_pkg::LN_NUM;
                cnt_next     = '0;
                state_next   = S_DIV1;
            end
            S_DIV1:
            begin
                lane_ctrl.op = dqpi_pkg::LN_DIV;
                cnt_next     = cnt_reg + 6'd1;
                if (cnt_reg == DIV_LAST)
                    state_next = S_MOD;
            end
            S_MOD:
            begin
                lane_ctrl.op = dqpi_pkg::LN_MOD;
                state_next   = S_SQR;
            end
            S_SQR:
            begin
                lane_ctrl.op = dqpi_pkg::LN_SQR;
                state_next   = S_SUM;
            end
            S_SUM:
            begin
                merge_ctrl.op = dqpi_pkg::MG_SUM;
                cnt_next      = '0;
                state_next    = S_CHK;
            end
            S_CHK:
                state_next = lim ? S_SQRT : S_OUTP;
            S_SQRT:
            begin
                merge_ctrl.op = dqpi_pkg::MG_STEP;
                cnt_next      = cnt_reg + 6'd1;
                if (cnt_reg == SQRT_LAST)
                    state_next = S_LOAD2;
            end
            S_LOAD2:
            begin
                lane_ctrl.op = dqpi_pkg::LN_LOAD2;
                cnt_next     = '0;
                state_next   = S_DIV2;
            end
            S_DIV2:
            begin
                lane_ctrl.op = dqpi_pkg::LN_DIV;
                cnt_next     = cnt_reg + 6'd1;
                if (cnt_reg == DIV_LAST)
                    state_next = S_OUTP;
            end
            S_OUTP:
            begin
                lane_ctrl.op = dqpi_pkg::LN_OUTP;
                state_next   = S_IMUL;
            end
            S_IMUL:
            begin
                lane_ctrl.op = dqpi_pkg::LN_IMUL;
                state_next   = S_INTEG;
            end
            S_INTEG:
            begin
                lane_ctrl.op = dqpi_pkg::LN_INTEG;
                state_next   = S_FIN;
            end
            S_FIN:
            begin
                // hold until the output register frees
                if (load_out)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            d_mod_reg   <= mod_d;
            q_mod_reg   <= mod_q;
            lim_out_reg <= lim;
        end
    end

    dqpi_lane u_lane_d (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (lane_ctrl),
        .reference   (d_reference),
        .measured    (d_measured),
        .prop_gain   (prop_gain_d_reg),
        .integ_gain  (integ_gain_d_reg),
        .bus_voltage (vb_eff),
        .magnitude   (magnitude),
        .square      (sq_d),
        .modulation  (mod_d)
    );

    dqpi_lane u_lane_q (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (lane_ctrl),
        .reference   (q_reference),
        .measured    (q_measured),
        .prop_gain   (prop_gain_q_reg),
        .integ_gain  (integ_gain_q_reg),
        .bus_voltage (vb_eff),
        .magnitude   (magnitude),
        .square      (sq_q),
        .modulation  (mod_q)
    );

    dqpi_merge u_merge (
        .clk       (clk),
        .ctrl      (merge_ctrl),
        .square_d  (sq_d),
        .square_q  (sq_q),
        .magnitude (magnitude),
        .limited   (lim)
    );

    assign out_valid    = out_valid_reg;
    assign d_modulation = d_mod_reg;
    assign q_modulation = q_mod_reg;
    assign limited      = lim_out_reg;

endmodule

### rtl/dqpi_checker.sv
module dqpi_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        cfg_write,
    input logic [2:0]  cfg_index,
    input logic [23:0] cfg_data,
    input logic        in_valid,
    input logic        in_ready,
    input logic [15:0] d_reference,
    input logic [15:0] q_reference,
    input logic [15:0] d_measured,
    input logic [15:0] q_measured,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] d_modulation,
    input logic [15:0] q_modulation,
    input logic        limited
);

    // a pending result holds until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(d_modulation)
            && $stable(q_modulation) && $stable(limited))
        else $error("output changed while stalled");

    // one request in work at a time
    a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second request taken while busy");

    // each axis of a limited result lies within plus or minus the limit radius
    a_limit_d: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && limited |-> ($signed(d_modulation) <= 16'sd11351)
            && ($signed(d_modulation) >= -16'sd11351))
        else $error("limited d modulation out of range");

    a_limit_q: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && limited |-> ($signed(q_modulation) <= 16'sd11351)
            && ($signed(q_modulation) >= -16'sd11351))
        else $error("limited q modulation out of range");

endmodule

bind dq_current_pi_with_modulation_limit_unit dqpi_checker u_dqpi_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .d_reference  (d_reference),
    .q_reference  (q_reference),
    .d_measured   (d_measured),
    .q_measured   (q_measured),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .d_modulation (d_modulation),
    .q_modulation (q_modulation),
    .limited      (limited)
);
